// File: design/ucm_pkg.sv
// ----------------------------------------------------------------------------
// ucm_pkg: shared types and ROM contents for the UTF-8 case mapper
// Case block table, page index, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ucm_pkg;

  localparam int TABLE_ENTRIES = 145;
  localparam int INDEX_PAGES   = 35;
  localparam int ROM_ROWS      = 145;
  localparam int ROM_PAGES     = 35;
  localparam int NENT = (TABLE_ENTRIES < ROM_ROWS) ? TABLE_ENTRIES : ROM_ROWS;
  localparam int NPG0 = (INDEX_PAGES < ROM_PAGES) ? INDEX_PAGES : ROM_PAGES;
  localparam int NPG  = (NPG0 < 1) ? 1 : NPG0;
  localparam int K_W  = $clog2(ROM_ROWS + 1);
  localparam int RI_W = $clog2(ROM_ROWS);
  localparam int PG_W = (ROM_PAGES > 1) ? $clog2(ROM_PAGES) : 1;

  typedef struct packed {
    logic [15:0] up;
    logic [15:0] low;
    logic [7:0]  len;
  } blk_t;

  localparam blk_t BLOCKS [ROM_ROWS] = '{
    '{16'h0041,16'h0061,8'd26}, '{16'h00c0,16'h00e0,8'd23}, '{16'h00d8,16'h00f8,8'd7},
    '{16'h0100,16'h0101,8'd48}, '{16'h0130,16'h0069,8'd1},  '{16'h0132,16'h0133,8'd6},
    '{16'h0139,16'h013a,8'd16}, '{16'h014a,16'h014b,8'd46}, '{16'h0178,16'h00ff,8'd1},
    '{16'h0179,16'h017a,8'd6},  '{16'h0181,16'h0253,8'd1},  '{16'h0182,16'h0183,8'd4},
    '{16'h0186,16'h0254,8'd1},  '{16'h0187,16'h0188,8'd2},  '{16'h0189,16'h0256,8'd2},
    '{16'h018b,16'h018c,8'd2},  '{16'h018e,16'h01dd,8'd1},  '{16'h018f,16'h0259,8'd1},
    '{16'h0190,16'h025b,8'd1},  '{16'h0191,16'h0192,8'd2},  '{16'h0193,16'h0260,8'd1},
    '{16'h0194,16'h0263,8'd1},  '{16'h0196,16'h0269,8'd1},  '{16'h0197,16'h0268,8'd1},
    '{16'h0198,16'h0199,8'd2},  '{16'h019c,16'h026f,8'd1},  '{16'h019d,16'h0272,8'd1},
    '{16'h019f,16'h0275,8'd1},  '{16'h01a0,16'h01a1,8'd6},  '{16'h01a6,16'h0280,8'd1},
    '{16'h01a7,16'h01a8,8'd2},  '{16'h01a9,16'h0283,8'd1},  '{16'h01ac,16'h01ad,8'd2},
    '{16'h01ae,16'h0288,8'd1},  '{16'h01af,16'h01b0,8'd2},  '{16'h01b1,16'h028a,8'd2},
    '{16'h01b3,16'h01b4,8'd4},  '{16'h01b7,16'h0292,8'd1},  '{16'h01b8,16'h01b9,8'd2},
    '{16'h01bc,16'h01bd,8'd2},  '{16'h01c4,16'h01c6,8'd1},  '{16'h01c5,16'h01c6,8'd2},
    '{16'h01c7,16'h01c9,8'd1},  '{16'h01c8,16'h01c9,8'd2},  '{16'h01ca,16'h01cc,8'd1},
    '{16'h01cb,16'h01cc,8'd18}, '{16'h01de,16'h01df,8'd18}, '{16'h01f1,16'h01f3,8'd1},
    '{16'h01f2,16'h01f3,8'd4},  '{16'h01f6,16'h0195,8'd1},  '{16'h01f7,16'h01bf,8'd1},
    '{16'h01f8,16'h01f9,8'd40}, '{16'h0220,16'h019e,8'd1},  '{16'h0222,16'h0223,8'd18},
    '{16'h023a,16'h2c65,8'd1},  '{16'h023b,16'h023c,8'd2},  '{16'h023d,16'h019a,8'd1},
    '{16'h023e,16'h2c66,8'd1},  '{16'h0241,16'h0242,8'd2},  '{16'h0243,16'h0180,8'd1},
    '{16'h0244,16'h0289,8'd1},  '{16'h0245,16'h028c,8'd1},  '{16'h0246,16'h0247,8'd10},
    '{16'h0370,16'h0371,8'd4},  '{16'h0376,16'h0377,8'd2},  '{16'h0386,16'h03ac,8'd1},
    '{16'h0388,16'h03ad,8'd3},  '{16'h038c,16'h03cc,8'd1},  '{16'h038e,16'h03cd,8'd2},
    '{16'h0391,16'h03b1,8'd17}, '{16'h03a3,16'h03c3,8'd9},  '{16'h03cf,16'h03d7,8'd1},
    '{16'h03d8,16'h03d9,8'd24}, '{16'h03f4,16'h03b8,8'd1},  '{16'h03f7,16'h03f8,8'd2},
    '{16'h03f9,16'h03f2,8'd1},  '{16'h03fa,16'h03fb,8'd2},  '{16'h03fd,16'h037b,8'd3},
    '{16'h0400,16'h0450,8'd16}, '{16'h0410,16'h0430,8'd32}, '{16'h0460,16'h0461,8'd34},
    '{16'h048a,16'h048b,8'd54}, '{16'h04c0,16'h04cf,8'd1},  '{16'h04c1,16'h04c2,8'd14},
    '{16'h04d0,16'h04d1,8'd84}, '{16'h0531,16'h0561,8'd38}, '{16'h10a0,16'h2d00,8'd38},
    '{16'h1e00,16'h1e01,8'd150},'{16'h1e9e,16'h00df,8'd1},  '{16'h1ea0,16'h1ea1,8'd96},
    '{16'h1f08,16'h1f00,8'd8},  '{16'h1f18,16'h1f10,8'd6},  '{16'h1f28,16'h1f20,8'd8},
    '{16'h1f38,16'h1f30,8'd8},  '{16'h1f48,16'h1f40,8'd6},  '{16'h1f59,16'h1f51,8'd1},
    '{16'h1f5b,16'h1f53,8'd1},  '{16'h1f5d,16'h1f55,8'd1},  '{16'h1f5f,16'h1f57,8'd1},
    '{16'h1f68,16'h1f60,8'd8},  '{16'h1f88,16'h1f80,8'd8},  '{16'h1f98,16'h1f90,8'd8},
    '{16'h1fa8,16'h1fa0,8'd8},  '{16'h1fb8,16'h1fb0,8'd2},  '{16'h1fba,16'h1f70,8'd2},
    '{16'h1fbc,16'h1fb3,8'd1},  '{16'h1fc8,16'h1f72,8'd4},  '{16'h1fcc,16'h1fc3,8'd1},
    '{16'h1fd8,16'h1fd0,8'd2},  '{16'h1fda,16'h1f76,8'd2},  '{16'h1fe8,16'h1fe0,8'd2},
    '{16'h1fea,16'h1f7a,8'd2},  '{16'h1fec,16'h1fe5,8'd1},  '{16'h1ff8,16'h1f78,8'd2},
    '{16'h1ffa,16'h1f7c,8'd2},  '{16'h1ffc,16'h1ff3,8'd1},  '{16'h2126,16'h03c9,8'd1},
    '{16'h212a,16'h006b,8'd1},  '{16'h212b,16'h00e5,8'd1},  '{16'h2132,16'h214e,8'd1},
    '{16'h2160,16'h2170,8'd16}, '{16'h2183,16'h2184,8'd2},  '{16'h24b6,16'h24d0,8'd26},
    '{16'h2c00,16'h2c30,8'd47}, '{16'h2c60,16'h2c61,8'd2},  '{16'h2c62,16'h026b,8'd1},
    '{16'h2c63,16'h1d7d,8'd1},  '{16'h2c64,16'h027d,8'd1},  '{16'h2c67,16'h2c68,8'd6},
    '{16'h2c6d,16'h0251,8'd1},  '{16'h2c6e,16'h0271,8'd1},  '{16'h2c6f,16'h0250,8'd1},
    '{16'h2c72,16'h2c73,8'd2},  '{16'h2c75,16'h2c76,8'd2},  '{16'h2c80,16'h2c81,8'd100},
    '{16'ha640,16'ha641,8'd32}, '{16'ha662,16'ha663,8'd12}, '{16'ha680,16'ha681,8'd24},
    '{16'ha722,16'ha723,8'd14}, '{16'ha732,16'ha733,8'd62}, '{16'ha779,16'ha77a,8'd4},
    '{16'ha77d,16'h1d79,8'd1},  '{16'ha77e,16'ha77f,8'd10}, '{16'ha78b,16'ha78c,8'd2},
    '{16'hff21,16'hff41,8'd26}
  };

  localparam logic [7:0] PAGE_START [ROM_PAGES] = '{
    8'd0, 8'd3, 8'd51, 8'd63, 8'd78, 8'd84, 8'd86, 8'd86, 8'd86, 8'd86, 8'd86, 8'd86,
    8'd86, 8'd86, 8'd86, 8'd86, 8'd86, 8'd87, 8'd87, 8'd87, 8'd87, 8'd87, 8'd87, 8'd87,
    8'd87, 8'd87, 8'd87, 8'd87, 8'd87, 8'd87, 8'd87, 8'd90, 8'd116, 8'd116, 8'd122
  };

  typedef enum logic [1:0] {ST_IDLE, ST_PICK, ST_SCAN, ST_EMIT} state_t;

  typedef struct packed {
    logic accept;
    logic load0;
    logic load1;
    logic step;
    logic map;
    logic advance;
  } ucm_cmd_t;

  typedef struct packed {
    logic qv0;
    logic qv1;
    logic scan_done;
    logic final_byte;
  } ucm_sts_t;

endpackage

// File: design/ucm_ctrl.sv
// ----------------------------------------------------------------------------
// ucm_ctrl: sequencer for the UTF-8 case mapper
// Accepts one byte, then maps and emits each queued character in turn.
// ----------------------------------------------------------------------------
module ucm_ctrl import ucm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  ucm_sts_t sts,
  output ucm_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_PICK;
      end
      ST_PICK: begin
        if (sts.qv0 || sts.qv1) state_next = ST_SCAN;
        else                    state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (m_tready && sts.final_byte) state_next = ST_PICK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      ST_PICK: begin
        cmd.load0 = sts.qv0;
        cmd.load1 = !sts.qv0 && sts.qv1;
      end
      ST_SCAN: begin
        cmd.step = !sts.scan_done;
        cmd.map  = sts.scan_done;
      end
      ST_EMIT: begin
        m_tvalid    = 1'b1;
        cmd.advance = m_tready && !sts.final_byte;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: design/ucm_dp.sv
// ----------------------------------------------------------------------------
// ucm_dp: datapath of the UTF-8 case mapper
// Decoder state, character queue, table scan, case map and UTF-8 encoder.
// ----------------------------------------------------------------------------
module ucm_dp import ucm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic       cfg_wdata,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  ucm_cmd_t   cmd,
  output ucm_sts_t   sts,
  output logic [7:0] out_byte,
  output logic       out_last
);

  function automatic logic [7:0] strip_lead(input logic [7:0] b);
    logic [7:0] c;
    logic       run;
    c   = b ^ 8'hc0;
    run = 1'b1;
    for (int i = 5; i >= 0; i--) begin
      if (run && c[i]) c[i] = 1'b0;
      else             run  = 1'b0;
    end
    return c;
  endfunction

  logic            to_upper;
  logic [31:0]     pend_code;
  logic            pend_valid;
  logic [31:0]     q0, q1;
  logic            qv0, qv1;
  logic            qlast;
  logic [31:0]     cur;
  logic [K_W-1:0]  k;
  logic [31:0]     res;
  logic [1:0]      idx;

  logic            cont;
  logic [31:0]     acc;
  logic [31:0]     stripped;
  logic [31:0]     ld_code;
  logic [PG_W-1:0] pg;
  logic [RI_W-1:0] ri;
  blk_t            ent;
  logic [15:0]     base;
  logic [32:0]     base_end;
  logic            k_in;
  logic            hit;
  logic            pair;
  logic [31:0]     off;
  logic [31:0]     mapped;
  logic [1:0]      nb;

  assign cont     = pend_valid && (in_byte[7:6] == 2'b10);
  assign acc      = {pend_code[25:0], in_byte[5:0]};
  assign stripped = {24'd0, strip_lead(in_byte)};
  assign ld_code  = cmd.load0 ? q0 : q1;

  always_comb begin
    if (ld_code[31:8] >= 24'(NPG)) pg = PG_W'(NPG - 1);
    else                           pg = ld_code[PG_W+7:8];
  end

  assign k_in     = (k < K_W'(NENT));
  assign ri       = k_in ? k[RI_W-1:0] : '0;
  assign ent      = BLOCKS[ri];
  assign base     = to_upper ? ent.low : ent.up;
  assign base_end = {17'd0, base} + {25'd0, ent.len};
  assign sts.scan_done = !k_in || (base_end > {1'b0, cur});
  assign hit      = k_in && (cur >= {16'd0, base}) && ({1'b0, cur} < base_end);
  assign pair     = ({1'b0, ent.low} == ({1'b0, ent.up} + 17'd1));
  assign off      = cur - {16'd0, base};

  always_comb begin
    mapped = cur;
    if (hit) begin
      if (pair) begin
        if (!off[0]) mapped = to_upper ? cur - 32'd1 : cur + 32'd1;
      end else if (to_upper) begin
        mapped = cur - {16'd0, ent.low} + {16'd0, ent.up};
      end else begin
        mapped = cur + {16'd0, ent.low} - {16'd0, ent.up};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      to_upper   <= 1'b0;
      pend_code  <= '0;
      pend_valid <= 1'b0;
      qv0        <= 1'b0;
      qv1        <= 1'b0;
    end else begin
      if (cfg_wen) to_upper <= cfg_wdata;
      if (cmd.accept) begin
        qlast <= in_last;
        if (cont) begin
          qv1 <= 1'b0;
          q0  <= acc;
          qv0 <= in_last;
          if (in_last) begin
            pend_valid <= 1'b0;
            pend_code  <= '0;
          end else begin
            pend_code <= acc;
          end
        end else begin
          qv0 <= pend_valid;
          q0  <= pend_code;
          if (!in_byte[7]) begin
            q1         <= {24'd0, in_byte};
            qv1        <= 1'b1;
            pend_valid <= 1'b0;
            pend_code  <= '0;
          end else if (in_last) begin
            q1         <= stripped;
            qv1        <= 1'b1;
            pend_valid <= 1'b0;
            pend_code  <= '0;
          end else begin
            qv1        <= 1'b0;
            pend_valid <= 1'b1;
            pend_code  <= stripped;
          end
        end
      end
      if (cmd.load0) qv0 <= 1'b0;
      if (cmd.load1) qv1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load0 || cmd.load1) begin
      cur <= ld_code;
      k   <= K_W'(PAGE_START[pg]);
    end else if (cmd.step) begin
      k <= k + K_W'(1);
    end
    if (cmd.map) begin
      res <= mapped;
      idx <= 2'd0;
    end else if (cmd.advance) begin
      idx <= idx + 2'd1;
    end
  end

  always_comb begin
    if      (res < 32'h80)    nb = 2'd0;
    else if (res < 32'h0800)  nb = 2'd1;
    else if (res < 32'h10000) nb = 2'd2;
    else                      nb = 2'd3;
  end

  always_comb begin
    out_byte = res[7:0];
    case (nb)
      2'd0: out_byte = res[7:0];
      2'd1: begin
        if (idx == 2'd0) out_byte = 8'hc0 | {3'd0, res[10:6]};
        else             out_byte = {2'b10, res[5:0]};
      end
      2'd2: begin
        case (idx)
          2'd0:    out_byte = {4'he, res[15:12]};
          2'd1:    out_byte = {2'b10, res[11:6]};
          default: out_byte = {2'b10, res[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    out_byte = 8'hf0 | res[25:18];
          2'd1:    out_byte = {2'b10, res[17:12]};
          2'd2:    out_byte = {2'b10, res[11:6]};
          default: out_byte = {2'b10, res[5:0]};
        endcase
      end
    endcase
  end

  assign sts.final_byte = (idx == nb);
  assign sts.qv0        = qv0;
  assign sts.qv1        = qv1;
  assign out_last       = qlast && (idx == nb) && !qv0 && !qv1;

endmodule

// File: design/utf8_case_mapper.sv
// ----------------------------------------------------------------------------
// utf8_case_mapper: streaming UTF-8 upper/lower case conversion
// Decodes UTF-8 bytes, maps each character through the case block ROM and
// re-encodes it as one to four UTF-8 bytes.
//
//   channel   direction  payload
//   s_axis    in         tdata: in_byte[7:0]; tlast: in_last
//   m_axis    out        tdata: out_byte[7:0]; tlast: out_last
//   cfg       in         cfg_wdata: to_upper
//
// Each byte is accepted in the idle state; then every character that it
// completes is selected, looked up by a table scan (entries stepped from the
// page start, one per cycle), mapped and emitted as its output bytes, and a
// final select returns to accept. A byte that only extends a pending
// character passes through the select state and returns to accept.
// Reset clears the pending character and selects lower case.
// A stalled output holds the byte and blocks further input.
// ----------------------------------------------------------------------------
module utf8_case_mapper import ucm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic       cfg_wdata,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte[7:0]
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte[7:0]
  output logic       m_tlast
);

  ucm_cmd_t cmd;
  ucm_sts_t sts;

  ucm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ucm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
